// ===== design/brlb_pkg.sv =====
// ----------------------------------------------------------------------------
// brlb_pkg
// shared types and constants for the size-budgeted lru residency table
// ----------------------------------------------------------------------------
package brlb_pkg;

  localparam int ROW_W    = 24;  // rows in a block, row offset
  localparam int SIZE_W   = 24;  // block size in words
  localparam int GROW_W   = 29;  // global row number of an access
  localparam int WORD_W   = 30;  // words in use, budget, global row bounds
  localparam int STAMP_W  = 32;  // access clock and stamps
  localparam int BLK_W    = 5;   // block index field
  localparam int MASK_W   = 32;  // evicted mask field
  localparam int ALU_W    = 32;  // shared add/subtract unit width

  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 96;

  // slave tdata layout
  localparam int S_ROWS_LSB = 0;
  localparam int S_SIZE_LSB = S_ROWS_LSB + ROW_W;
  localparam int S_GROW_LSB = S_SIZE_LSB + SIZE_W;

  // master tdata layout
  localparam int M_BLK_LSB   = 0;
  localparam int M_OFF_LSB   = M_BLK_LSB + BLK_W;
  localparam int M_WAS_BIT   = M_OFF_LSB + ROW_W;
  localparam int M_MASK_LSB  = M_WAS_BIT + 1;
  localparam int M_WORDS_LSB = M_MASK_LSB + MASK_W;
  localparam int M_PAD_W     = M_TDATA_W - (M_WORDS_LSB + WORD_W);

  localparam logic [WORD_W-1:0] BUDGET_RESET = WORD_W'(1048576);
  localparam logic [WORD_W-1:0] WORD_MAX     = '1;

  localparam logic OP_DEFINE = 1'b0;
  localparam logic OP_ACCESS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BUDGET = 2'd3
  } status_t;

  // request to the shared add/subtract unit
  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  // carry out is the inverted borrow when subtracting
  typedef struct packed {
    logic             carry;
    logic [ALU_W-1:0] sum;
  } alu_rsp_t;

endpackage

// ===== design/brlb_alu.sv =====
// ----------------------------------------------------------------------------
// brlb_alu
// shared add/subtract unit used for row lookup, lru compare and word accounting
// ----------------------------------------------------------------------------
module brlb_alu import brlb_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ALU_W-1:0] b_op;
  logic [ALU_W:0]   total;

  // a - b as a + ~b + 1
  assign b_op  = req.sub ? ~req.b : req.b;
  assign total = {1'b0, req.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, req.sub};

  assign rsp.carry = total[ALU_W];
  assign rsp.sum   = total[ALU_W-1:0];

endmodule

// ===== design/block_residency_lru_budget.sv =====
// ----------------------------------------------------------------------------
// block_residency_lru_budget
// block table with word-budgeted lru residency, one item in flight at a time
// ----------------------------------------------------------------------------
// s_tdata/s_tuser carry one item: s_tuser 0 defines the next block (row count
// and size in words), 1 accesses a global row. Each item yields one result
// item on m_tdata/m_tuser, m_tuser holding the status code.
// A define, and an access to a row past the last defined row, go straight
// to S_DONE. Otherwise the access walks the block table in order, through
// S_LK_A and S_LK_B for each block up to the owner, then S_LK_C; a hit then
// goes to S_DONE. A miss compares words in use against word_budget in
// S_EV_CHK; every eviction is a full lru scan of all NUM_BLOCKS entries
// through S_SC_A/S_SC_B, then S_RM_A and S_RM_B, and the load runs through
// S_LD_A and S_LD_B. All of this runs on the one add/subtract unit.
// s_tready is high only while no item is being worked on. A finished result
// sits in the output register, the block takes the next item meanwhile, and
// holds the following result until m_tready frees the register.
// Reset empties the table and the resident set and restores the budget; the
// block tables need no clearing pass. word_budget is written through
// cfg_wen/cfg_wdata; write it only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module block_residency_lru_budget import brlb_pkg::*; #(
  parameter int NUM_BLOCKS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // row_count[23:0], block_size_words[47:24], row_number[76:48], zero pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  // op
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // block_index[4:0], row_in_block[28:5], was_resident[29],
  // evicted_mask[61:30], resident_words[91:62], zero pad
  output logic [M_TDATA_W-1:0] m_tdata,
  // status
  output logic [1:0]           m_tuser,
  input  logic                 cfg_wen,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_LK_A   = 12'b0000_0000_0010,
    S_LK_B   = 12'b0000_0000_0100,
    S_LK_C   = 12'b0000_0000_1000,
    S_EV_CHK = 12'b0000_0001_0000,
    S_SC_A   = 12'b0000_0010_0000,
    S_SC_B   = 12'b0000_0100_0000,
    S_RM_A   = 12'b0000_1000_0000,
    S_RM_B   = 12'b0001_0000_0000,
    S_LD_A   = 12'b0010_0000_0000,
    S_LD_B   = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // block tables: bounds and size written once per define, stamps on hit and load
  logic [WORD_W-1:0]  first_row_mem [NUM_BLOCKS];
  logic [WORD_W-1:0]  end_row_mem   [NUM_BLOCKS];
  logic [SIZE_W-1:0]  size_mem      [NUM_BLOCKS];
  logic [STAMP_W-1:0] stamp_mem     [NUM_BLOCKS];

  logic [WORD_W-1:0]  rd_first;
  logic [WORD_W-1:0]  rd_end;
  logic [SIZE_W-1:0]  rd_size;
  logic [STAMP_W-1:0] rd_stamp;

  logic [WORD_W-1:0]     word_budget;
  logic [NUM_BLOCKS-1:0] resident;
  logic [WORD_W-1:0]     words;
  logic [CNT_W-1:0]      blocks_defined;
  logic [WORD_W-1:0]     rows_defined;
  logic [STAMP_W-1:0]    access_clock;

  // working registers of the item in progress
  logic [GROW_W-1:0]     row;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      blk;
  logic [IDX_W-1:0]      victim;
  logic [STAMP_W-1:0]    best;
  logic                  any;
  logic [ROW_W-1:0]      off;
  logic                  was;
  logic [NUM_BLOCKS-1:0] ev;
  status_t               st;

  logic                  accept;
  logic                  table_full;
  logic [WORD_W-1:0]     end_new;
  logic                  tbl_we;
  logic [IDX_W-1:0]      rd_addr;
  logic                  stamp_we;
  logic [IDX_W-1:0]      stamp_wa;
  logic [STAMP_W-1:0]    clock_inc;
  logic                  lk_last;
  logic                  out_free;
  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;
  logic                  borrow;

  brlb_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign table_full = (blocks_defined >= CNT_W'(NUM_BLOCKS));
  assign end_new    = rows_defined + WORD_W'(s_tdata[S_ROWS_LSB +: ROW_W]);
  assign tbl_we     = accept && (s_tuser == OP_DEFINE) && !table_full;
  assign clock_inc  = access_clock + STAMP_W'(1);
  assign lk_last    = ((CNT_W'(idx) + CNT_W'(1)) == blocks_defined);
  assign out_free   = !m_tvalid || m_tready;
  assign borrow     = !alu_rsp.carry;

  assign stamp_we = ((state == S_LK_C) && resident[idx]) || (state == S_LD_B);
  assign stamp_wa = (state == S_LK_C) ? idx : blk;

  always_comb begin
    case (state)
      S_RM_A, S_RM_B: rd_addr = victim;
      S_LD_A, S_LD_B: rd_addr = blk;
      default:        rd_addr = idx;
    endcase
  end

  // operand select for the shared unit
  always_comb begin
    alu_req.sub = 1'b1;
    alu_req.a   = '0;
    alu_req.b   = '0;
    case (state)
      S_LK_B: begin
        alu_req.a = ALU_W'(row);
        alu_req.b = ALU_W'(rd_end);
      end
      S_LK_C: begin
        alu_req.a = ALU_W'(row);
        alu_req.b = ALU_W'(rd_first);
      end
      S_SC_B: begin
        alu_req.a = rd_stamp;
        alu_req.b = best;
      end
      S_EV_CHK: begin
        alu_req.a = ALU_W'(words);
        alu_req.b = ALU_W'(word_budget);
      end
      S_RM_B: begin
        alu_req.a = ALU_W'(words);
        alu_req.b = ALU_W'(rd_size);
      end
      S_LD_B: begin
        alu_req.sub = 1'b0;
        alu_req.a   = ALU_W'(words);
        alu_req.b   = ALU_W'(rd_size);
      end
      default: begin
        alu_req.sub = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      first_row_mem[blocks_defined[IDX_W-1:0]] <= rows_defined;
      end_row_mem[blocks_defined[IDX_W-1:0]]   <= end_new;
      size_mem[blocks_defined[IDX_W-1:0]]      <= s_tdata[S_SIZE_LSB +: SIZE_W];
    end
    rd_first <= first_row_mem[rd_addr];
    rd_end   <= end_row_mem[rd_addr];
    rd_size  <= size_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_wa] <= clock_inc;
    end
    rd_stamp <= stamp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_budget <= BUDGET_RESET;
    end else if (cfg_wen) begin
      word_budget <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      resident       <= '0;
      words          <= '0;
      blocks_defined <= '0;
      rows_defined   <= '0;
      access_clock   <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            ev  <= '0;
            was <= 1'b0;
            off <= '0;
            if (s_tuser == OP_DEFINE) begin
              if (table_full) begin
                st  <= ST_FULL;
                blk <= '0;
              end else begin
                st             <= ST_OK;
                blk            <= blocks_defined[IDX_W-1:0];
                rows_defined   <= end_new;
                blocks_defined <= blocks_defined + CNT_W'(1);
              end
              state <= S_DONE;
            end else if (WORD_W'(s_tdata[S_GROW_LSB +: GROW_W]) < rows_defined) begin
              blk   <= '0;
              row   <= s_tdata[S_GROW_LSB +: GROW_W];
              idx   <= '0;
              state <= S_LK_A;
            end else begin
              blk   <= '0;
              st    <= ST_RANGE;
              state <= S_DONE;
            end
          end
        end
        S_LK_A: begin
          state <= S_LK_B;
        end
        S_LK_B: begin
          // earlier blocks all end at or below the row, so row < end means owner
          if (borrow) begin
            state <= S_LK_C;
          end else if (lk_last) begin
            st    <= ST_RANGE;
            state <= S_DONE;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_LK_A;
          end
        end
        S_LK_C: begin
          off <= alu_rsp.sum[ROW_W-1:0];
          blk <= idx;
          if (resident[idx]) begin
            access_clock <= clock_inc;
            was          <= 1'b1;
            st           <= ST_OK;
            state        <= S_DONE;
          end else begin
            state <= S_EV_CHK;
          end
        end
        S_EV_CHK: begin
          if (!borrow) begin
            idx   <= '0;
            any   <= 1'b0;
            state <= S_SC_A;
          end else begin
            state <= S_LD_A;
          end
        end
        S_SC_A: begin
          state <= S_SC_B;
        end
        S_SC_B: begin
          // strict less keeps the lowest index on a tie
          if (resident[idx] && (!any || borrow)) begin
            victim <= idx;
            best   <= rd_stamp;
            any    <= 1'b1;
          end
          if (idx == LAST_IDX) begin
            if (any || resident[idx]) begin
              state <= S_RM_A;
            end else begin
              st    <= ST_BUDGET;
              state <= S_DONE;
            end
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_SC_A;
          end
        end
        S_RM_A: begin
          state <= S_RM_B;
        end
        S_RM_B: begin
          words            <= borrow ? '0 : alu_rsp.sum[WORD_W-1:0];
          resident[victim] <= 1'b0;
          ev[victim]       <= 1'b1;
          state            <= S_EV_CHK;
        end
        S_LD_A: begin
          state <= S_LD_B;
        end
        S_LD_B: begin
          // sum stays below 2^31, so bit 30 flags the overflow
          words         <= alu_rsp.sum[WORD_W] ? WORD_MAX : alu_rsp.sum[WORD_W-1:0];
          resident[blk] <= 1'b1;
          access_clock  <= clock_inc;
          st            <= ST_OK;
          state         <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if ((state == S_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload, loaded as the item completes
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      m_tdata <= {{M_PAD_W{1'b0}}, words, MASK_W'(ev), was, off, BLK_W'(blk)};
      m_tuser <= st;
    end
  end

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[M_WAS_BIT]) |-> (m_tdata[M_MASK_LSB +: MASK_W] == '0))
    else $error("resident hit reported evictions");

  // table full only once every block is defined
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_FULL)) |-> (blocks_defined == CNT_W'(NUM_BLOCKS)))
    else $error("table full reported with free entries");

  // evicted blocks stay out of the resident set for the item
  a_evict_gone: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> ((ev & resident) == '0))
    else $error("evicted block still resident");

  // resident set only moves on an eviction or a load
  a_resident_moves: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(resident)) |->
      ($past(state) == S_RM_B || $past(state) == S_LD_B))
    else $error("resident set changed outside evict or load");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks block_residency_lru_budget: block defines, row lookups, lru eviction
// under several word budgets, against a cycle-free prediction of the table
// ----------------------------------------------------------------------------
module testbench import brlb_pkg::*; ();

  localparam int NBLK = 32;

  typedef struct packed {
    logic              op;
    logic [ROW_W-1:0]  row_count;
    logic [SIZE_W-1:0] size_words;
    logic [GROW_W-1:0] row_number;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic [BLK_W-1:0]  blk;
    logic [ROW_W-1:0]  offset;
    logic              was_resident;
    logic [MASK_W-1:0] evicted;
    logic [WORD_W-1:0] words;
  } outcome_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [1:0]           m_tuser;
  logic                 cfg_wen;
  logic [WORD_W-1:0]    cfg_wdata;

  block_residency_lru_budget #(.NUM_BLOCKS(NBLK)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  // predicted table state
  logic [ROW_W-1:0]   blk_rows  [NBLK];
  logic [WORD_W-1:0]  blk_base  [NBLK];
  logic [SIZE_W-1:0]  blk_words [NBLK];
  bit                 blk_loaded[NBLK];
  logic [STAMP_W-1:0] blk_stamp [NBLK];
  logic [WORD_W-1:0]  words_held;
  logic [WORD_W-1:0]  total_rows;
  logic [STAMP_W-1:0] use_clock;
  logic [WORD_W-1:0]  budget_words;
  int                 nblocks;

  // layout of the blocks as planned by the stimulus
  int unsigned plan_base[NBLK];
  int unsigned plan_rows[NBLK];
  int unsigned plan_total;
  int          plan_blocks;

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  request_t cur_req;
  bit       item_live;
  bit       item_taken;
  int       src_gap;
  int       sink_hold;
  int       src_gap_pct;
  int       sink_stall_pct;
  int       mismatch_count;

  function automatic outcome_t predict_residency(input request_t it);
    outcome_t         r;
    longint unsigned  n;
    longint unsigned  sum;
    int               owner;
    int               victim;
    bit               any;
    logic [STAMP_W-1:0] oldest;
    r = '0;
    r.status = ST_OK;
    if (it.op == OP_DEFINE) begin
      if (nblocks >= NBLK) begin
        r.status = ST_FULL;
      end else begin
        blk_rows[nblocks]  = it.row_count;
        blk_base[nblocks]  = total_rows;
        blk_words[nblocks] = it.size_words;
        total_rows = total_rows + WORD_W'(it.row_count);
        r.blk = BLK_W'(nblocks);
        nblocks++;
      end
      r.words = words_held;
      return r;
    end
    n = it.row_number;
    owner = -1;
    if (n < total_rows) begin
      for (int i = 0; i < nblocks && owner < 0; i++) begin
        if (n >= blk_base[i] && n - blk_base[i] < blk_rows[i]) owner = i;
      end
    end
    if (owner < 0) begin
      r.status = ST_RANGE;
      r.words = words_held;
      return r;
    end
    r.blk = BLK_W'(owner);
    r.offset = ROW_W'(n - blk_base[owner]);
    if (blk_loaded[owner]) begin
      use_clock++;
      blk_stamp[owner] = use_clock;
      r.was_resident = 1'b1;
      r.words = words_held;
      return r;
    end
    while (words_held >= budget_words) begin
      any = 1'b0;
      victim = 0;
      oldest = '0;
      for (int i = 0; i < NBLK; i++) begin
        if (blk_loaded[i] && (!any || blk_stamp[i] < oldest)) begin
          any = 1'b1;
          victim = i;
          oldest = blk_stamp[i];
        end
      end
      // nothing left to throw out: evictions so far stand, no load
      if (!any) begin
        r.status = ST_BUDGET;
        r.words = words_held;
        return r;
      end
      blk_loaded[victim] = 1'b0;
      if (words_held >= blk_words[victim]) words_held = words_held - blk_words[victim];
      else words_held = '0;
      r.evicted[victim] = 1'b1;
    end
    blk_loaded[owner] = 1'b1;
    sum = longint'(words_held) + blk_words[owner];
    words_held = (sum > WORD_MAX) ? WORD_MAX : sum[WORD_W-1:0];
    use_clock++;
    blk_stamp[owner] = use_clock;
    r.words = words_held;
    return r;
  endfunction

  task automatic queue_define(input int unsigned rows, input int unsigned words);
    request_t it;
    it = '0;
    it.op = OP_DEFINE;
    it.row_count = rows[ROW_W-1:0];
    it.size_words = words[SIZE_W-1:0];
    it.row_number = GROW_W'($urandom);
    pending_requests = {pending_requests, it};
    if (plan_blocks < NBLK) begin
      plan_base[plan_blocks] = plan_total;
      plan_rows[plan_blocks] = it.row_count;
      plan_total += it.row_count;
      plan_blocks++;
    end
  endtask

  task automatic queue_access(input int unsigned row);
    request_t it;
    it.op = OP_ACCESS;
    it.row_count = ROW_W'($urandom);
    it.size_words = SIZE_W'($urandom);
    it.row_number = row[GROW_W-1:0];
    pending_requests = {pending_requests, it};
  endtask

  // mostly accesses to owned rows with a hot group of blocks, some noise
  task automatic queue_mix(input int count);
    int          b;
    int          pick;
    int unsigned row;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        queue_define($urandom, $urandom);
      end else if (pick < 13) begin
        case ($urandom_range(0, 2))
          0: row = plan_total;
          1: row = $urandom_range(29'h1FFF_FFFF, plan_total);
          default: row = $urandom & 29'h1FFF_FFFF;
        endcase
        queue_access(row);
      end else begin
        b = (pick < 50) ? $urandom_range(1, 6) : $urandom_range(0, plan_blocks - 1);
        while (plan_rows[b] == 0) b = $urandom_range(0, plan_blocks - 1);
        case ($urandom_range(0, 3))
          0: row = plan_base[b];
          1: row = plan_base[b] + plan_rows[b] - 1;
          default: row = plan_base[b] + $urandom_range(plan_rows[b] - 1, 0);
        endcase
        queue_access(row);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || item_live || expected_outcomes.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input logic [WORD_W-1:0] budget, input int count,
                           input int gap_pct, input int stall_pct);
    wait_drained();
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= budget;
    @(negedge clk);
    cfg_wen <= 1'b0;
    budget_words = budget;
    src_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    queue_mix(count);
  endtask

  task automatic report_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $time, msg);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // sender
  always @(negedge clk) begin
    logic [S_TDATA_W-1:0] req;
    if (!rst) begin
      if (item_taken) begin
        item_taken = 1'b0;
        item_live = 1'b0;
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct)
          src_gap = $urandom_range(1, 14);
      end
      if (!item_live) begin
        if (src_gap != 0) begin
          src_gap--;
        end else if (pending_requests.size() != 0) begin
          cur_req = pending_requests.pop_front();
          item_live = 1'b1;
        end
      end
      s_tvalid <= item_live;
      if (item_live) begin
        req = '0;
        req[S_ROWS_LSB +: ROW_W]  = cur_req.row_count;
        req[S_SIZE_LSB +: SIZE_W] = cur_req.size_words;
        req[S_GROW_LSB +: GROW_W] = cur_req.row_number;
        s_tdata <= req;
        s_tuser <= cur_req.op;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (sink_hold != 0) begin
      sink_hold--;
      m_tready <= 1'b0;
    end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
      sink_hold = $urandom_range(1, 14) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // item acceptance and result checking
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_outcomes = {expected_outcomes, predict_residency(cur_req)};
        item_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        got.status       = status_t'(m_tuser);
        got.blk          = m_tdata[M_BLK_LSB +: BLK_W];
        got.offset       = m_tdata[M_OFF_LSB +: ROW_W];
        got.was_resident = m_tdata[M_WAS_BIT];
        got.evicted      = m_tdata[M_MASK_LSB +: MASK_W];
        got.words        = m_tdata[M_WORDS_LSB +: WORD_W];
        if (expected_outcomes.size() == 0) begin
          report_failure("result item with none expected");
        end else begin
          want = expected_outcomes.pop_front();
          if (got.status !== want.status)
            report_failure($sformatf("status exp %0d got %0d", want.status, got.status));
          if (got.blk !== want.blk)
            report_failure($sformatf("block_index exp %0d got %0d", want.blk, got.blk));
          if (got.offset !== want.offset)
            report_failure($sformatf("row_in_block exp %0d got %0d", want.offset, got.offset));
          if (got.was_resident !== want.was_resident)
            report_failure($sformatf("was_resident exp %0d got %0d",
                                     want.was_resident, got.was_resident));
          if (got.evicted !== want.evicted)
            report_failure($sformatf("evicted_mask exp %h got %h", want.evicted, got.evicted));
          if (got.words !== want.words)
            report_failure($sformatf("resident_words exp %0d got %0d", want.words, got.words));
        end
      end
    end
  end

  initial begin
    int unsigned rows;
    int unsigned words;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_DEFINE;
    m_tready = 1'b0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    item_live = 1'b0;
    item_taken = 1'b0;
    src_gap = 0;
    sink_hold = 0;
    src_gap_pct = 10;
    sink_stall_pct = 15;
    mismatch_count = 0;
    for (int i = 0; i < NBLK; i++) begin
      blk_rows[i] = '0;
      blk_base[i] = '0;
      blk_words[i] = '0;
      blk_loaded[i] = 1'b0;
      blk_stamp[i] = '0;
    end
    words_held = '0;
    total_rows = '0;
    use_clock = '0;
    budget_words = BUDGET_RESET;
    nblocks = 0;
    plan_total = 0;
    plan_blocks = 0;

    // directed part at the reset budget
    queue_access(0);                   // nothing defined yet
    queue_define(0, 7);                // empty block, owns no row
    queue_define(1, 0);                // one row, zero size
    queue_define(24'hFF_FFFF, 24'hFF_FFFF);
    queue_define(100, 1000);
    queue_access(0);                   // miss, load of a zero-size block
    queue_access(0);                   // hit
    queue_access(1);                   // big block, first row
    queue_access(32'h0100_0000);       // over budget: two lru evictions
    queue_access(32'h0100_0000 + 99);
    queue_access(24'hFF_FFFF);         // big block, last row, reloaded
    queue_access(32'h0100_0000 + 100); // one past the last row
    queue_access(29'h1FFF_FFFF);
    for (int k = 0; k < NBLK - 4; k++) begin
      case ($urandom_range(0, 3))
        0: rows = $urandom_range(1, 64);
        1: rows = $urandom_range(0, 16'hFFFF);
        default: rows = $urandom_range(0, 24'hFF_FFFF);
      endcase
      case ($urandom_range(0, 3))
        0: words = $urandom_range(0, 4096);
        1: words = $urandom_range(0, 1 << 20);
        2: words = $urandom_range(0, 24'hFF_FFFF);
        default: words = $urandom_range(1 << 18, 1 << 22);
      endcase
      queue_define(rows, words);
    end
    // table is full from here on
    queue_define(24'hFF_FFFF, 24'hFF_FFFF);
    queue_define(0, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_phase(BUDGET_RESET, 280, 20, 20);
    run_phase('0, 60, 10, 30);          // every miss ends with budget unmet
    run_phase(WORD_W'(1), 150, 20, 10);
    run_phase(WORD_W'(536870912), 200, 0, 0);
    run_phase(WORD_MAX, 100, 30, 30);
    run_phase(WORD_W'($urandom_range(1 << 26, 1 << 20)), 300, 15, 25);
    run_phase(WORD_W'(4194304), 500, 0, 0);

    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
